/* design/pfb_pkg.sv */
package pfb_pkg;

	localparam int COLUMNS  = 128;
	localparam int PAGES    = 8;
	localparam int FB_SIZE  = COLUMNS * PAGES;
	localparam int PIX_ROWS = PAGES * 8;
	localparam int AW       = $clog2(FB_SIZE);
	localparam int CW       = $clog2(COLUMNS);
	localparam int RW       = $clog2(PIX_ROWS);

	localparam logic [2:0] KIND_CHAR  = 3'd0;
	localparam logic [2:0] KIND_HLINE = 3'd1;
	localparam logic [2:0] KIND_VLINE = 3'd2;
	localparam logic [2:0] KIND_CLEAR = 3'd3;
	localparam logic [2:0] KIND_READ  = 3'd4;

	typedef struct packed {
		logic [2:0] kind;
		logic [7:0] char_code;
		logic       first_char;
		logic [2:0] text_line;
		logic [6:0] text_column;
		logic [6:0] fixed_coord;
		logic [6:0] span_start;
		logic [6:0] span_end;
		logic [9:0] read_index;
	} in_item_t;

	typedef struct packed {
		logic [7:0] read_byte;
		logic       halted;
		logic       rejected;
	} out_item_t;

	// back-end operation codes
	typedef enum logic [2:0] {
		OP_NOP, OP_GLYPH, OP_SPACE, OP_HLINE, OP_VLINE, OP_CLEAR, OP_READ
	} op_t;

	// classified command passed from front to back
	typedef struct packed {
		op_t        op;
		logic       first;
		logic [AW:0] start;
		logic [4:0] glyph;      // letter 0..25 or digit 0..9
		logic       digit;
		logic [7:0] lo;
		logic [7:0] hi;
		logic [7:0] fixed;
		logic       reject;
		logic [9:0] ridx;
	} cmd_t;

	typedef enum logic [2:0] {
		ST_IDLE, ST_GLYPH, ST_LINE_RD, ST_LINE_WR, ST_CLEAR, ST_READ, ST_DONE
	} st_t;

	function automatic logic [7:0] letter_col(input logic [4:0] l, input logic [2:0] c);
		logic [47:0] g;
		case (l)
			5'd0:  g = 48'hF8_14_12_14_F8_00;
			5'd1:  g = 48'hFE_92_92_92_6C_00;
			5'd2:  g = 48'h38_44_82_82_44_00;
			5'd3:  g = 48'hFE_82_82_44_38_00;
			5'd4:  g = 48'hFE_92_92_92_92_00;
			5'd5:  g = 48'hFE_12_12_02_02_00;
			5'd6:  g = 48'h38_44_92_92_72_00;
			5'd7:  g = 48'hFE_10_10_10_FE_00;
			5'd8:  g = 48'h82_82_FE_82_82_00;
			5'd9:  g = 48'h42_82_7E_02_02_00;
			5'd10: g = 48'hFE_10_28_44_82_00;
			5'd11: g = 48'hFE_80_80_80_80_00;
			5'd12: g = 48'hFC_02_FC_02_FC_00;
			5'd13: g = 48'hFE_0C_10_60_FE_00;
			5'd14: g = 48'h38_44_82_44_38_00;
			5'd15: g = 48'hFE_12_12_12_0C_00;
			5'd16: g = 48'h38_44_A2_44_B8_00;
			5'd17: g = 48'hFE_12_32_52_8C_00;
			5'd18: g = 48'h4C_92_92_92_64_00;
			5'd19: g = 48'h02_02_FE_02_02_00;
			5'd20: g = 48'h7E_80_80_80_7E_00;
			5'd21: g = 48'h3E_40_80_40_3E_00;
			5'd22: g = 48'h7E_80_78_80_7E_00;
			5'd23: g = 48'hC6_28_10_28_C6_00;
			5'd24: g = 48'h06_08_F0_08_06_00;
			5'd25: g = 48'h86_8A_92_A2_C2_00;
			default: g = '0;
		endcase
		case (c)
			3'd0: letter_col = g[47:40];
			3'd1: letter_col = g[39:32];
			3'd2: letter_col = g[31:24];
			3'd3: letter_col = g[23:16];
			3'd4: letter_col = g[15:8];
			3'd5: letter_col = g[7:0];
			default: letter_col = 8'h00;
		endcase
	endfunction

	function automatic logic [7:0] digit_col(input logic [4:0] d, input logic [2:0] c);
		logic [31:0] g;
		case (d)
			5'd0: g = 32'hFE_82_FE_00;
			5'd1: g = 32'h84_FE_80_00;
			5'd2: g = 32'hF2_92_9E_00;
			5'd3: g = 32'h92_92_FE_00;
			5'd4: g = 32'h1E_10_FE_00;
			5'd5: g = 32'h9E_92_F2_00;
			5'd6: g = 32'hFE_92_F2_00;
			5'd7: g = 32'h02_02_FE_00;
			5'd8: g = 32'hFE_92_FE_00;
			5'd9: g = 32'h1E_12_FE_00;
			default: g = '0;
		endcase
		case (c)
			3'd0: digit_col = g[31:24];
			3'd1: digit_col = g[23:16];
			3'd2: digit_col = g[15:8];
			3'd3: digit_col = g[7:0];
			default: digit_col = 8'h00;
		endcase
	endfunction

endpackage

/* design/pfb_front.sv */
module pfb_front (
	input  logic               clk,
	input  logic               arst_n,
	input  pfb_pkg::in_item_t  item,
	input  logic               push,
	output logic               full,
	output pfb_pkg::cmd_t      cmd,
	output logic               cmd_valid,
	input  logic               cmd_take
);
	import pfb_pkg::*;

	localparam int QD = 2;

	cmd_t       q_q [QD];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;
	cmd_t       c;
	logic       do_push, do_pop;
	logic [7:0] cc;

	always_comb begin
		cc = item.char_code;
		c = '0;
		c.op = OP_NOP;
		c.first = item.first_char;
		c.start = (AW+1)'(item.text_line) * (AW+1)'(COLUMNS) + (AW+1)'(item.text_column);
		c.lo = 8'(item.span_start);
		c.hi = 8'(item.span_end);
		c.fixed = 8'(item.fixed_coord);
		c.ridx = item.read_index;
		unique case (item.kind)
			KIND_CHAR: begin
				if (cc >= 8'h41 && cc <= 8'h5A) begin
					c.op = OP_GLYPH; c.glyph = 5'(cc - 8'h41);
				end else if (cc >= 8'h61 && cc <= 8'h7A) begin
					c.op = OP_GLYPH; c.glyph = 5'(cc - 8'h61);
				end else if (cc >= 8'h30 && cc <= 8'h39) begin
					c.op = OP_GLYPH; c.glyph = 5'(cc - 8'h30); c.digit = 1'b1;
				end else if (cc == 8'h20) begin
					c.op = OP_SPACE;
				end
				// first_char still applies for ignored characters
			end
			KIND_HLINE: begin
				c.op = OP_HLINE;
				c.reject = (32'(item.fixed_coord) > PIX_ROWS - 1) ||
					(32'(item.span_start) > COLUMNS - 1) || (32'(item.span_end) > COLUMNS - 1) ||
					(item.span_end <= item.span_start);
			end
			KIND_VLINE: begin
				c.op = OP_VLINE;
				c.reject = (32'(item.fixed_coord) > COLUMNS - 1) ||
					(32'(item.span_start) > PIX_ROWS - 1) || (32'(item.span_end) > PIX_ROWS - 1) ||
					(item.span_end <= item.span_start);
			end
			KIND_CLEAR: c.op = OP_CLEAR;
			KIND_READ:  c.op = OP_READ;
			default:    c.op = OP_NOP;
		endcase
		if (item.kind != KIND_CHAR) c.first = 1'b0;
	end

	assign full      = (cnt_q == 2'(QD));
	assign cmd_valid = (cnt_q != 2'd0);
	assign cmd       = q_q[rp_q];
	assign do_push   = push && !full;
	assign do_pop    = cmd_take && cmd_valid;

	always_ff @(posedge clk) begin
		if (do_push) q_q[wp_q] <= c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= '0;
		end else begin
			if (do_push) wp_q <= !wp_q;
			if (do_pop)  rp_q <= !rp_q;
			cnt_q <= cnt_q + 2'(do_push) - 2'(do_pop);
		end
	end

	a_cnt: assert property (@(posedge clk) disable iff (!arst_n) cnt_q <= 2'(QD))
		else $error("queue overflow");
	a_pop: assert property (@(posedge clk) disable iff (!arst_n) cnt_q == 2'd0 |-> !do_pop)
		else $error("pop from empty");
	a_ptr: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q == 2'(QD) || cnt_q == 2'd0 |-> wp_q == rp_q)
		else $error("pointer mismatch");

endmodule

/* design/pfb_back.sv */
module pfb_back (
	input  logic                clk,
	input  logic                arst_n,
	input  pfb_pkg::cmd_t       cmd,
	input  logic                cmd_valid,
	output logic                cmd_take,
	output pfb_pkg::out_item_t  res,
	output logic                empty,
	input  logic                pop
);
	import pfb_pkg::*;

	logic [7:0]  mem [FB_SIZE];
	logic [7:0]  rdata_q;

	st_t         st_q, st_d;
	cmd_t        c_q;
	logic [AW:0] cur_q, cur_d;
	logic        halt_q, halt_d;
	logic [2:0]  j_q, j_d;
	logic [7:0]  i_q, i_d;
	logic [AW:0] clr_q, clr_d;
	logic        clr_busy_q;
	logic        rvalid_q;
	out_item_t   res_q, res_d;
	out_item_t   acc_q, acc_d;
	logic        res_load;

	logic        we;
	logic [AW-1:0] wa, ra;
	logic [7:0]  wd;
	logic        start_cmd;
	logic [AW:0] cbase;
	logic [CW-1:0] col;
	logic [2:0]  w;
	logic [AW:0] gpos;
	logic [AW+1:0] sp;
	logic [AW-1:0] la;
	logic [7:0]  lmask;

	always_ff @(posedge clk) begin
		if (we) mem[wa] <= wd;
		rdata_q <= mem[ra];
	end

	assign start_cmd = (st_q == ST_IDLE) && cmd_valid && !clr_busy_q;
	assign cmd_take  = start_cmd;
	assign empty     = !rvalid_q;
	assign res       = res_q;

	always_comb begin
		// line address for the current step
		if (c_q.op == OP_HLINE) begin
			la = AW'((AW+1)'(c_q.fixed[RW-1:3]) * (AW+1)'(COLUMNS) + (AW+1)'(i_q));
			lmask = 8'(1) << c_q.fixed[2:0];
		end else begin
			la = AW'((AW+1)'(i_q[RW-1:3]) * (AW+1)'(COLUMNS) + (AW+1)'(c_q.fixed));
			lmask = 8'(1) << i_q[2:0];
		end
	end

	always_comb begin
		st_d = st_q; cur_d = cur_q; halt_d = halt_q; j_d = j_q; i_d = i_q;
		clr_d = clr_q; res_d = res_q; acc_d = acc_q; res_load = 1'b0;
		we = 1'b0; wa = la; wd = rdata_q | lmask; ra = la;
		cbase = cur_q; col = '0; w = '0; gpos = '0; sp = '0;
		unique case (st_q)
			ST_IDLE: begin
				if (start_cmd) begin
					acc_d = '0;
					j_d = '0;
					i_d = cmd.lo;
					cbase = cur_q;
					if (cmd.first) begin
						cbase = (cmd.start > (AW+1)'(FB_SIZE)) ? (AW+1)'(FB_SIZE) : cmd.start;
						halt_d = 1'b0;
					end
					col = CW'(cbase);
					cur_d = cbase;
					unique case (cmd.op)
						OP_GLYPH: begin
							if (!halt_d) begin
								w = cmd.digit ? 3'd4 : 3'd6;
								gpos = cbase;
								if (32'(col) + 32'(w) > COLUMNS - 1)
									gpos = cbase + (AW+1)'(COLUMNS) - (AW+1)'(col);
								cur_d = gpos;
								if (32'(gpos) + 32'(w) >= FB_SIZE) halt_d = 1'b1;
								else st_d = ST_GLYPH;
							end
						end
						OP_SPACE: begin
							if (!halt_d) begin
								if (32'(col) + 6 > COLUMNS - 1)
									sp = (AW+2)'(cbase) + (AW+2)'(COLUMNS) - (AW+2)'(col);
								else
									sp = (AW+2)'(cbase) + (AW+2)'(4);
								cur_d = (sp > (AW+2)'(FB_SIZE)) ? (AW+1)'(FB_SIZE)
									: (AW+1)'(sp);
							end
						end
						OP_HLINE, OP_VLINE: begin
							acc_d.rejected = cmd.reject;
							if (!cmd.reject) st_d = ST_LINE_RD;
						end
						OP_CLEAR: begin
							clr_d = '0;
							st_d = ST_CLEAR;
						end
						OP_READ: st_d = ST_READ;
						default: ;
					endcase
					acc_d.halted = halt_d;
					if (st_d == ST_IDLE) st_d = ST_DONE;
				end
			end
			ST_GLYPH: begin
				we = 1'b1;
				wa = AW'(cur_q + (AW+1)'(j_q));
				wd = c_q.digit ? digit_col(c_q.glyph, j_q) : letter_col(c_q.glyph, j_q);
				j_d = j_q + 3'd1;
				if (j_q == (c_q.digit ? 3'd3 : 3'd5)) begin
					cur_d = cur_q + (c_q.digit ? (AW+1)'(4) : (AW+1)'(6));
					st_d = ST_DONE;
				end
			end
			ST_LINE_RD: st_d = ST_LINE_WR;
			ST_LINE_WR: begin
				we = 1'b1;
				i_d = i_q + 8'd1;
				st_d = (i_q == c_q.hi) ? ST_DONE : ST_LINE_RD;
			end
			ST_CLEAR: begin
				we = 1'b1;
				wa = AW'(clr_q);
				wd = 8'h00;
				clr_d = clr_q + (AW+1)'(1);
				if (clr_q == (AW+1)'(FB_SIZE - 1)) st_d = ST_DONE;
			end
			ST_READ: begin
				ra = c_q.ridx[AW-1:0];
				st_d = ST_DONE;
				if (32'(c_q.ridx) >= FB_SIZE) st_d = ST_DONE;
			end
			ST_DONE: begin
				// keep the read address so the byte survives an output stall
				ra = c_q.ridx[AW-1:0];
				if (!rvalid_q || pop) begin
					res_load = 1'b1;
					res_d = acc_q;
					if (c_q.op == OP_READ && 32'(c_q.ridx) < FB_SIZE)
						res_d.read_byte = rdata_q;
					st_d = ST_IDLE;
				end
			end
			default: st_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (start_cmd) c_q <= cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_CLEAR; cur_q <= '0; halt_q <= 1'b0; j_q <= '0; i_q <= '0;
			clr_q <= '0; clr_busy_q <= 1'b1; rvalid_q <= 1'b0; res_q <= '0;
			acc_q <= '0;
		end else begin
			cur_q <= cur_d; halt_q <= halt_d; j_q <= j_d; i_q <= i_d; clr_q <= clr_d;
			res_q <= res_d;
			acc_q <= acc_d;
			if (clr_busy_q) begin
				st_q <= (st_d == ST_DONE) ? ST_IDLE : st_d;
				if (st_d == ST_DONE) clr_busy_q <= 1'b0;
			end else begin
				st_q <= st_d;
			end
			if (res_load) rvalid_q <= 1'b1;
			else if (pop && rvalid_q) rvalid_q <= 1'b0;
		end
	end

	a_cur: assert property (@(posedge clk) disable iff (!arst_n) cur_q <= (AW+1)'(FB_SIZE))
		else $error("cursor beyond buffer");
	a_take: assert property (@(posedge clk) disable iff (!arst_n) cmd_take |-> cmd_valid)
		else $error("take without command");
	a_gl: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == ST_GLYPH |-> 32'(cur_q) + 6 <= FB_SIZE + 2)
		else $error("glyph past end");
	a_res: assert property (@(posedge clk) disable iff (!arst_n)
		res_load |=> !empty)
		else $error("result lost");

endmodule

/* design/page_framebuffer_text_and_line_drawer_unit.sv */
// Engine work per item: a glyph writes its columns one by one, a line does a
// read-modify-write per byte, and a clear sweeps the whole framebuffer.
// Throughput: one item at a time in the drawing engine; a 2-deep command
// queue lets the front accept while the engine works.
// Reset: asynchronous, active low; afterwards a clearing pass zeroes the
// framebuffer while no command is started.
module page_framebuffer_text_and_line_drawer_unit (
	input  logic                clk,
	input  logic                arst_n,
	input  pfb_pkg::in_item_t   item,
	input  logic                push,
	output logic                full,
	output pfb_pkg::out_item_t  result,
	output logic                empty,
	input  logic                pop
);
	import pfb_pkg::*;

	// command transfer between classifier and drawing engine
	cmd_t cmd;
	logic cmd_valid, cmd_take;

	pfb_front u_front (
		.clk, .arst_n, .item, .push, .full,
		.cmd, .cmd_valid, .cmd_take
	);

	// engine: glyph writes, line read-modify-write, clear sweep, byte read;
	// its result register is the output queue head
	pfb_back u_back (
		.clk, .arst_n, .cmd, .cmd_valid, .cmd_take,
		.res(result), .empty, .pop
	);

endmodule
